[sv/spf_pkg.sv]
package spf_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned CountW       = 5;
  localparam int unsigned PrefillW     = 8;
  localparam int unsigned CreditW      = 8;
  localparam int unsigned CfgDataW     = 8;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned DropFillMin  = 5;

  localparam logic [CountW-1:0]  SlotCountReset = CountW'(16);
  localparam logic [CreditW-1:0] CreditMax      = '1;

  localparam logic [CfgIdxW-1:0] CfgSlotCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPrefill   = 1'b1;

  typedef enum logic [1:0] {
    OpPush   = 2'd0,
    OpPop    = 2'd1,
    OpCredit = 2'd2,
    OpClear  = 2'd3
  } spf_op_e;

  typedef enum logic [2:0] {
    StatOk         = 3'd0,
    StatNotStarted = 3'd1,
    StatDropped    = 3'd2,
    StatFull       = 3'd3,
    StatHeld       = 3'd4,
    StatEmpty      = 3'd5,
    StatBadEntry   = 3'd6
  } spf_status_e;

  typedef enum logic [1:0] {
    StIdle,
    StRing,
    StSlot
  } spf_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic        drop_check;
    logic [31:0] payload;
    logic [15:0] length;
    logic [30:0] frames;
  } spf_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_payload;
    logic [15:0] out_length;
    logic [30:0] out_frame_count;
    logic [4:0]  depth;
  } spf_out_t;

  typedef struct packed {
    logic [31:0] payload;
    logic [15:0] length;
    logic [30:0] frames;
  } spf_entry_t;

endpackage

[sv/slot_pool_packet_fifo_unit.sv]
// Packet queue over a pool of slots, driven one command transaction at a time.
// A command is taken at the clock edge where start_i is high and busy_o is low;
// item_i carries the operation and, for a push, the packet fields.
// Every command yields exactly one result on result_o, marked by done_o for a
// single cycle. The receiver cannot stall, so done_o is never held back.
// Push, credit add, clear and any pop that does not dequeue finish without
// leaving idle: the result appears in the cycle after acceptance and busy_o stays low,
// so such commands may be issued every cycle.
// A pop that dequeues reads the order ring and then the slot memory, each through
// a registered read: busy_o stays high through states StRing and StSlot, and the
// result appears as busy_o falls, so no new command is taken until that pop is through.
// The configuration port writes slot_count (index 0) and prefill_level
// (index 1) at any edge where cfg_we_i is high; write only while idle.
// Reset frees all slots, empties the queue, disarms it, clears the prefill
// latch and the drop credits, and loads slot_count 16 and prefill_level 0.
module slot_pool_packet_fifo_unit #(
  parameter int unsigned SLOTS = spf_pkg::SlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  spf_pkg::spf_in_t             item_i,
  output logic                         busy_o,
  input  logic                         cfg_we_i,
  input  logic [spf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spf_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         done_o,
  output spf_pkg::spf_out_t            result_o
);
  import spf_pkg::*;

  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FillW = $clog2(SLOTS + 1);

  spf_state_e          state_q, state_d;
  logic                armed_q, armed_d;
  logic                met_q, met_d;
  logic [CreditW-1:0]  credits_q, credits_d;
  logic [CountW-1:0]   slot_count_q;
  logic [PrefillW-1:0] prefill_q;
  logic                done_q, done_d;
  spf_status_e         status_q, status_d;
  spf_entry_t          res_q, res_d;

  logic                accept;
  logic                clear;
  logic                push_en;
  logic                pop_en;
  logic                rd_en;
  logic                free_en;
  logic                found;
  logic [IdxW-1:0]     free_slot;
  logic [IdxW-1:0]     head_slot;
  logic [FillW-1:0]    fill;
  spf_entry_t          wr_data;
  spf_entry_t          rd_data;

  assign accept  = start_i && (state_q == StIdle);
  assign wr_data = '{payload: item_i.payload, length: item_i.length,
                     frames: item_i.frames};

  spf_pool #(
    .SLOTS(SLOTS)
  ) u_pool (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_count_i(slot_count_q),
    .clear_i     (clear),
    .wr_en_i     (push_en),
    .wr_idx_i    (free_slot),
    .wr_data_i   (wr_data),
    .free_en_i   (free_en),
    .free_idx_i  (head_slot),
    .rd_en_i     (rd_en),
    .rd_idx_i    (head_slot),
    .rd_data_o   (rd_data),
    .found_o     (found),
    .free_slot_o (free_slot)
  );

  spf_ring #(
    .SLOTS(SLOTS)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear),
    .push_en_i  (push_en),
    .push_slot_i(free_slot),
    .pop_en_i   (pop_en),
    .fill_o     (fill),
    .head_slot_o(head_slot)
  );

  always_comb begin
    state_d   = state_q;
    armed_d   = armed_q;
    met_d     = met_q;
    credits_d = credits_q;
    done_d    = 1'b0;
    status_d  = status_q;
    res_d     = '0;
    clear     = 1'b0;
    push_en   = 1'b0;
    pop_en    = 1'b0;
    rd_en     = 1'b0;
    free_en   = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          done_d   = 1'b1;
          status_d = StatOk;
          case (spf_op_e'(item_i.operation))
            OpPush: begin
              if (!armed_q) begin
                status_d = StatNotStarted;
              end else if (item_i.drop_check && (credits_q != '0) &&
                           (32'(fill) > DropFillMin)) begin
                credits_d = credits_q - CreditW'(1);
                status_d  = StatDropped;
              end else if (!found || (32'(fill) >= SLOTS)) begin
                status_d = StatFull;
              end else begin
                push_en = 1'b1;
              end
            end
            OpPop: begin
              if (!armed_q) begin
                armed_d  = 1'b1;
                status_d = StatNotStarted;
              end else if (!met_q && (prefill_q != '0) &&
                           (32'(prefill_q) > 32'(fill))) begin
                status_d = StatHeld;
              end else begin
                met_d = 1'b1;
                if (fill == '0) begin
                  status_d = StatEmpty;
                end else begin
                  pop_en  = 1'b1;
                  done_d  = 1'b0;
                  state_d = StRing;
                end
              end
            end
            OpCredit: begin
              if (credits_q != CreditMax) begin
                credits_d = credits_q + CreditW'(1);
              end
            end
            OpClear: begin
              clear     = 1'b1;
              credits_d = '0;
            end
            default: begin
              status_d = StatOk;
            end
          endcase
        end
      end
      StRing: begin
        rd_en   = 1'b1;
        state_d = StSlot;
      end
      StSlot: begin
        done_d  = 1'b1;
        state_d = StIdle;
        if (rd_data.length == '0) begin
          status_d = StatBadEntry;
        end else begin
          status_d = StatOk;
          res_d    = rd_data;
          free_en  = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      armed_q      <= 1'b0;
      met_q        <= 1'b0;
      credits_q    <= '0;
      done_q       <= 1'b0;
      status_q     <= StatOk;
      slot_count_q <= SlotCountReset;
      prefill_q    <= '0;
    end else begin
      state_q   <= state_d;
      armed_q   <= armed_d;
      met_q     <= met_d;
      credits_q <= credits_d;
      done_q    <= done_d;
      status_q  <= status_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSlotCount: slot_count_q <= cfg_data_i[CountW-1:0];
          CfgPrefill:   prefill_q    <= cfg_data_i[PrefillW-1:0];
          default: begin
            prefill_q <= prefill_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o                   = (state_q != StIdle);
  assign done_o                   = done_q;
  assign result_o.status          = status_q;
  assign result_o.out_payload     = res_q.payload;
  assign result_o.out_length      = res_q.length;
  assign result_o.out_frame_count = res_q.frames;
  assign result_o.depth           = 5'(fill);

endmodule

[sv/spf_pool.sv]
module spf_pool #(
  parameter int unsigned SLOTS = spf_pkg::SlotsDefault,
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [spf_pkg::CountW-1:0] slot_count_i,
  input  logic                       clear_i,
  input  logic                       wr_en_i,
  input  logic [IdxW-1:0]            wr_idx_i,
  input  spf_pkg::spf_entry_t        wr_data_i,
  input  logic                       free_en_i,
  input  logic [IdxW-1:0]            free_idx_i,
  input  logic                       rd_en_i,
  input  logic [IdxW-1:0]            rd_idx_i,
  output spf_pkg::spf_entry_t        rd_data_o,
  output logic                       found_o,
  output logic [IdxW-1:0]            free_slot_o
);
  import spf_pkg::*;

  logic [SLOTS-1:0] busy_q, busy_d;
  spf_entry_t       slot_mem_q [SLOTS];
  spf_entry_t       rd_data_q;

  always_comb begin
    found_o     = 1'b0;
    free_slot_o = '0;
    for (int i = int'(SLOTS) - 1; i >= 0; i--) begin
      if (!busy_q[i] && (i < int'(slot_count_i))) begin
        found_o     = 1'b1;
        free_slot_o = IdxW'(i);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (clear_i) begin
      busy_d = '0;
    end else begin
      if (wr_en_i) begin
        busy_d[wr_idx_i] = 1'b1;
      end
      if (free_en_i) begin
        busy_d[free_idx_i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= slot_mem_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/spf_ring.sv]
module spf_ring #(
  parameter int unsigned SLOTS = spf_pkg::SlotsDefault,
  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned FillW = $clog2(SLOTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             push_en_i,
  input  logic [IdxW-1:0]  push_slot_i,
  input  logic             pop_en_i,
  output logic [FillW-1:0] fill_o,
  output logic [IdxW-1:0]  head_slot_o
);
  import spf_pkg::*;

  localparam int unsigned SumW = FillW + 1;

  logic [IdxW-1:0]  head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [SumW-1:0]  tail_sum;
  logic [IdxW-1:0]  tail;
  logic [IdxW-1:0]  ring_mem_q [SLOTS];
  logic [IdxW-1:0]  head_slot_q;

  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(fill_q);
    if (tail_sum >= SumW'(SLOTS)) begin
      tail = IdxW'(tail_sum - SumW'(SLOTS));
    end else begin
      tail = IdxW'(tail_sum);
    end
  end

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (clear_i) begin
      head_d = '0;
      fill_d = '0;
    end else if (push_en_i) begin
      fill_d = fill_q + FillW'(1);
    end else if (pop_en_i) begin
      fill_d = fill_q - FillW'(1);
      if (head_q == IdxW'(SLOTS - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en_i) begin
      ring_mem_q[tail] <= push_slot_i;
    end
    if (pop_en_i) begin
      head_slot_q <= ring_mem_q[head_q];
    end
  end

  assign fill_o      = fill_q;
  assign head_slot_o = head_slot_q;

endmodule
